// File: hw/rtl/tqbrr_pkg.sv
`timescale 1ns / 1ps

package tqbrr_pkg;

	// Lane geometry
	localparam int LANE_DEPTH  = 16;
	localparam int LANE_COUNT  = 3;
	localparam int STORE_DEPTH = LANE_COUNT * LANE_DEPTH;

	localparam int IDX_W  = $clog2(LANE_DEPTH);
	localparam int CNT_W  = $clog2(LANE_DEPTH + 1);
	localparam int LANE_W = $clog2(LANE_COUNT);
	localparam int ADDR_W = $clog2(STORE_DEPTH);

	localparam int BURST_W     = 4;
	localparam int BURST_RESET = 3;

	// Input mode codes
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [LANE_W-1:0] lane_idx_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		ST_POPPED = 2'd0,
		ST_PUSHED = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic               mode;
		logic [1:0]         lane;
		logic signed [31:0] value;
	} in_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] out_value;
		logic [1:0]         out_lane;
	} out_t;

	// Flat store address of one lane slot
	function automatic addr_t store_addr(lane_idx_t ln, idx_t ix);
		return ADDR_W'(ADDR_W'(ln) * ADDR_W'(LANE_DEPTH)) + ADDR_W'(ix);
	endfunction

	// Ring index increment with wrap at LANE_DEPTH
	function automatic idx_t next_idx(idx_t ix);
		return (ix == IDX_W'(LANE_DEPTH - 1)) ? '0 : ix + 1'b1;
	endfunction

endpackage

// File: hw/rtl/tqbrr_store.sv
`timescale 1ns / 1ps

module tqbrr_store
	import tqbrr_pkg::*;
(
	input  logic        clk,
	input  logic        we,
	input  addr_t       waddr,
	input  logic [31:0] wdata,
	input  logic        re,
	input  addr_t       raddr,
	output logic [31:0] rdata
);

	logic [31:0] mem [STORE_DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/three_queue_burst_round_robin_merge.sv
`timescale 1ns / 1ps

// Three-lane burst round-robin merge. Each transaction on in_data is a push
// (mode 0) into one lane FIFO or a pop (mode 1) of the next item in burst
// round-robin order; every transaction yields one result on out_data. A push,
// a rejected push and a pop that finds all lanes empty register their result
// directly; a data-returning pop first reads the shared lane store through its
// registered read port. One transaction is in flight at a time; the next is
// accepted in the cycle its predecessor's result is taken. The store (48 x 32)
// needs no clearing pass: only entries covered by a lane's count are ever read.
// burst_length is written through cfg_data (reset 3, zero acts as 1).
module three_queue_burst_round_robin_merge
	import tqbrr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_t                in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_t               out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [BURST_W-1:0] cfg_data
);

	idx_t                 heads_q [LANE_COUNT];
	idx_t                 tails_q [LANE_COUNT];
	cnt_t                 counts_q [LANE_COUNT];
	lane_idx_t            cur_q;
	logic [BURST_W-1:0]   burst_used_q;
	logic [BURST_W-1:0]   burst_len_q;
	logic                 pend_s1;
	lane_idx_t            lane_s1;
	logic                 out_valid_q;
	out_t                 out_q;

	logic [LANE_COUNT-1:0] nonempty;
	logic [BURST_W-1:0]    limit;
	logic                  accept;
	logic                  is_push;
	logic                  push_ok;
	lane_idx_t             push_lane;
	logic                  stay;
	logic                  found;
	lane_idx_t             cand;
	lane_idx_t             sel;
	logic                  pop_go;
	logic [31:0]           rd_data;

	assign cfg_ready = 1'b1;
	assign in_ready  = !pend_s1 && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Lane occupancy flags
	always_comb begin
		for (int i = 0; i < LANE_COUNT; i++) begin
			nonempty[i] = (counts_q[i] != '0);
		end
	end

	assign limit     = (burst_len_q == '0) ? BURST_W'(1) : burst_len_q;
	assign is_push   = (in_data.mode == MODE_PUSH);
	assign push_lane = LANE_W'(in_data.lane);
	assign push_ok   = (32'(in_data.lane) < LANE_COUNT)
		&& (32'(counts_q[push_lane]) < LANE_DEPTH);

	// Next non-empty lane after the current one, wrapping back to it
	always_comb begin
		logic [LANE_W:0] sum;
		found = 1'b0;
		cand  = cur_q;
		for (int k = LANE_COUNT; k >= 1; k--) begin
			sum = (LANE_W + 1)'(cur_q) + (LANE_W + 1)'(k);
			if (32'(sum) >= LANE_COUNT) begin
				sum = sum - (LANE_W + 1)'(LANE_COUNT);
			end
			if (nonempty[LANE_W'(sum)]) begin
				found = 1'b1;
				cand  = LANE_W'(sum);
			end
		end
	end

	assign stay   = nonempty[cur_q] && (burst_used_q < limit);
	assign sel    = stay ? cur_q : cand;
	assign pop_go = accept && !is_push && (stay || found);

	tqbrr_store u_store (
		.clk   (clk),
		.we    (accept && is_push && push_ok),
		.waddr (store_addr(push_lane, tails_q[push_lane])),
		.wdata (in_data.value),
		.re    (pop_go),
		.raddr (store_addr(sel, heads_q[sel])),
		.rdata (rd_data)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_len_q <= BURST_W'(BURST_RESET);
		end else if (cfg_valid) begin
			burst_len_q <= cfg_data;
		end
	end

	// FIFO pointers, service state and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_COUNT; i++) begin
				heads_q[i]  <= '0;
				tails_q[i]  <= '0;
				counts_q[i] <= '0;
			end
			cur_q        <= '0;
			burst_used_q <= '0;
			pend_s1      <= 1'b0;
			lane_s1      <= '0;
		end else begin
			pend_s1 <= pop_go;
			if (accept && is_push && push_ok) begin
				tails_q[push_lane]  <= next_idx(tails_q[push_lane]);
				counts_q[push_lane] <= counts_q[push_lane] + 1'b1;
			end
			if (pop_go) begin
				heads_q[sel]  <= next_idx(heads_q[sel]);
				counts_q[sel] <= counts_q[sel] - 1'b1;
				cur_q         <= sel;
				lane_s1       <= sel;
				burst_used_q  <= stay ? burst_used_q + 1'b1 : BURST_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (accept) begin
			out_valid_q <= !pop_go;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			out_q.status    <= ST_POPPED;
			out_q.out_value <= rd_data;
			out_q.out_lane  <= 2'(lane_s1);
		end else if (accept && !pop_go) begin
			out_q.out_value <= '0;
			out_q.out_lane  <= '0;
			if (is_push) begin
				out_q.status <= push_ok ? ST_PUSHED : ST_FULL;
			end else begin
				out_q.status <= ST_EMPTY;
			end
		end
	end

`ifndef ASSERT_OFF
	// A store read in flight blocks new transactions
	a_pend_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !in_ready)
		else $error("transaction accepted during store read");

	// A started pop always passes through the read stage and then lands in the output register
	a_pop_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pop_go |=> (pend_s1 ##1 out_valid_q))
		else $error("pop result lost");

	// Current lane tracks a valid lane and burst count respects the limit
	a_burst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pop_go && stay |-> (burst_used_q < limit) && (32'(cur_q) < LANE_COUNT))
		else $error("burst continued past limit");

	// Popped results name an existing lane
	a_out_lane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status == ST_POPPED) |-> 32'(out_q.out_lane) < LANE_COUNT)
		else $error("popped item from nonexistent lane");
`endif

endmodule
